### hw/rtl/i2c_mra_pkg.sv
// Package for the I2C register-access master: bus phase encoding,
// command codes, configuration register indexes and reset values.
// No dependencies.
`default_nettype none

package i2c_mra_pkg;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START_A   = 4'd1,
        PH_START_B   = 4'd2,
        PH_BIT_LOW   = 4'd3,
        PH_BIT_HIGH  = 4'd4,
        PH_ACK_LOW   = 4'd5,
        PH_ACK_WAIT  = 4'd6,
        PH_RSTART    = 4'd7,
        PH_RD_LOW    = 4'd8,
        PH_RD_HIGH   = 4'd9,
        PH_MACK_LOW  = 4'd10,
        PH_MACK_HIGH = 4'd11,
        PH_STOP_A    = 4'd12,
        PH_STOP_B    = 4'd13,
        PH_STOP_C    = 4'd14
    } phase_t;

    typedef enum logic [1:0] {
        BYTE_DEV  = 2'd0,
        BYTE_REG  = 2'd1,
        BYTE_DATA = 2'd2
    } byte_sel_t;

    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic REG_HALF_PERIOD = 1'b0;
    localparam logic REG_ACK_TIMEOUT = 1'b1;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd1;
    localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd1000;

endpackage

`default_nettype wire

### hw/rtl/i2c_master_register_access.sv
// I2C master for single register writes and multi-byte register reads.
// One input word is one bus timing tick; uses i2c_mra_pkg.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+------------------------------------------
//   s_      | in        | s_valid / s_ready | func dev_byte reg_byte write_data
//           |           |                   | byte_count sda_in
//   m_      | out       | m_valid / m_ready | scl sda_out sda_is_output busy_res byte_valid
//           |           |                   | read_byte last_byte done_res status
//   cfg_    | in        | cfg_we            | cfg_addr cfg_wdata
//
// One word per cycle while no result is stalled: the bus state and the result
// register update in the cycle the word is taken, so each result appears in the
// cycle after its word. The output register accepts a new word while the held
// result is taken. Reset (aresetn low, synchronous) returns the bus to idle and
// the configuration to half period 1, acknowledge timeout 1000.
// A stalled result holds the input side: s_ready = !m_valid | m_ready.
`default_nettype none

module i2c_master_register_access (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [15:0] cfg_wdata,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [7:0]  s_dev_byte,
    input  wire logic [7:0]  s_reg_byte,
    input  wire logic [7:0]  s_write_data,
    input  wire logic [7:0]  s_byte_count,
    input  wire logic        s_sda_in,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_scl,
    output logic             m_sda_out,
    output logic             m_sda_is_output,
    output logic             m_busy_res,
    output logic             m_byte_valid,
    output logic [7:0]       m_read_byte,
    output logic             m_last_byte,
    output logic             m_done_res,
    output logic             m_status
);

    // configuration
    logic [15:0] half_period_reg;
    logic [15:0] ack_timeout_reg;

    // bus state
    i2c_mra_pkg::phase_t    phase_reg, phase_next, phase_eff;
    i2c_mra_pkg::byte_sel_t byte_no_reg, byte_no_next;
    logic [2:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [15:0] wait_count_reg, wait_count_next;
    logic [7:0]  saved_dev_reg, saved_dev_next;
    logic [7:0]  saved_reg_reg, saved_reg_next;
    logic [7:0]  saved_data_reg, saved_data_next;
    logic        is_read_reg, is_read_next;
    logic        failed_reg, failed_next;

    // result register
    logic        m_valid_reg, m_valid_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        drive_reg, drive_next;
    logic        busy_reg, busy_next;
    logic        bvalid_reg, bvalid_next;
    logic [7:0]  rbyte_reg, rbyte_next;
    logic        last_reg, last_next;
    logic        done_reg, done_next;
    logic        stat_reg, stat_next;

    logic        s_accept;
    logic        load_cmd;
    logic [15:0] tick_eff;
    logic [15:0] wait_eff;
    logic [15:0] half_lim;
    logic [15:0] ack_lim;
    logic [16:0] tick_inc;
    logic        half_over;
    logic [15:0] wait_inc;
    logic        ack_expired;
    logic [7:0]  shift_in;
    logic [7:0]  bytes_dec;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    assign load_cmd = (phase_reg == i2c_mra_pkg::PH_IDLE) &&
                      (s_func == i2c_mra_pkg::FUNC_WRITE || s_func == i2c_mra_pkg::FUNC_READ);
    assign phase_eff = load_cmd ? i2c_mra_pkg::PH_START_A : phase_reg;
    assign tick_eff  = load_cmd ? 16'd0 : tick_count_reg;
    assign wait_eff  = load_cmd ? 16'd0 : wait_count_reg;

    assign half_lim  = (half_period_reg == 16'd0) ? 16'd1 : half_period_reg;
    assign ack_lim   = (ack_timeout_reg == 16'd0) ? 16'd1 : ack_timeout_reg;
    assign tick_inc  = {1'b0, tick_eff} + 17'd1;
    assign half_over = tick_inc >= {1'b0, half_lim};
    assign wait_inc  = wait_eff + 16'd1;
    assign ack_expired = (wait_inc >= ack_lim) || (wait_inc == 16'd0);
    assign shift_in  = {shift_byte_reg[6:0], s_sda_in};
    assign bytes_dec = bytes_left_reg - 8'd1;

    // next state
    always_comb begin
        phase_next      = phase_eff;
        byte_no_next    = byte_no_reg;
        bit_index_next  = bit_index_reg;
        shift_byte_next = shift_byte_reg;
        bytes_left_next = bytes_left_reg;
        tick_count_next = half_over ? 16'd0 : tick_inc[15:0];
        wait_count_next = wait_eff;
        saved_dev_next  = saved_dev_reg;
        saved_reg_next  = saved_reg_reg;
        saved_data_next = saved_data_reg;
        is_read_next    = is_read_reg;
        failed_next     = failed_reg;

        if (load_cmd) begin
            saved_dev_next  = s_dev_byte;
            saved_reg_next  = s_reg_byte;
            saved_data_next = s_write_data;
            bytes_left_next = (s_byte_count == 8'd0) ? 8'd1 : s_byte_count;
            is_read_next    = (s_func == i2c_mra_pkg::FUNC_READ);
            byte_no_next    = i2c_mra_pkg::BYTE_DEV;
            failed_next     = 1'b0;
        end

        case (phase_eff)
            i2c_mra_pkg::PH_START_A: begin
                if (half_over) phase_next = i2c_mra_pkg::PH_START_B;
            end
            i2c_mra_pkg::PH_START_B: begin
                if (half_over) begin
                    shift_byte_next = (byte_no_next == i2c_mra_pkg::BYTE_DEV) ?
                                      saved_dev_next : saved_dev_next + 8'd1;
                    bit_index_next  = 3'd0;
                    phase_next      = i2c_mra_pkg::PH_BIT_LOW;
                end
            end
            i2c_mra_pkg::PH_BIT_LOW: begin
                if (half_over) phase_next = i2c_mra_pkg::PH_BIT_HIGH;
            end
            i2c_mra_pkg::PH_BIT_HIGH: begin
                if (half_over) begin
                    shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                    if (bit_index_reg == 3'd7) begin
                        bit_index_next  = 3'd0;
                        wait_count_next = 16'd0;
                        phase_next      = i2c_mra_pkg::PH_ACK_LOW;
                    end else begin
                        bit_index_next = bit_index_reg + 3'd1;
                        phase_next     = i2c_mra_pkg::PH_BIT_LOW;
                    end
                end
            end
            i2c_mra_pkg::PH_ACK_LOW: begin
                if (half_over) phase_next = i2c_mra_pkg::PH_ACK_WAIT;
            end
            i2c_mra_pkg::PH_ACK_WAIT: begin
                tick_count_next = tick_eff;
                if (!s_sda_in) begin
                    wait_count_next = 16'd0;
                    tick_count_next = 16'd0;
                    case (byte_no_reg)
                        i2c_mra_pkg::BYTE_DEV: begin
                            byte_no_next    = i2c_mra_pkg::BYTE_REG;
                            shift_byte_next = saved_reg_reg;
                            bit_index_next  = 3'd0;
                            phase_next      = i2c_mra_pkg::PH_BIT_LOW;
                        end
                        i2c_mra_pkg::BYTE_REG: begin
                            byte_no_next = i2c_mra_pkg::BYTE_DATA;
                            if (is_read_reg) begin
                                phase_next = i2c_mra_pkg::PH_RSTART;
                            end else begin
                                shift_byte_next = saved_data_reg;
                                bit_index_next  = 3'd0;
                                phase_next      = i2c_mra_pkg::PH_BIT_LOW;
                            end
                        end
                        default: begin
                            if (is_read_reg) begin
                                bit_index_next  = 3'd0;
                                shift_byte_next = 8'd0;
                                phase_next      = i2c_mra_pkg::PH_RD_LOW;
                            end else begin
                                phase_next = i2c_mra_pkg::PH_STOP_A;
                            end
                        end
                    endcase
                end else if (ack_expired) begin
                    failed_next     = 1'b1;
                    wait_count_next = 16'd0;
                    tick_count_next = 16'd0;
                    phase_next      = i2c_mra_pkg::PH_STOP_A;
                end else begin
                    wait_count_next = wait_inc;
                end
            end
            i2c_mra_pkg::PH_RSTART: begin
                if (half_over) phase_next = i2c_mra_pkg::PH_START_A;
            end
            i2c_mra_pkg::PH_RD_LOW: begin
                if (half_over) phase_next = i2c_mra_pkg::PH_RD_HIGH;
            end
            i2c_mra_pkg::PH_RD_HIGH: begin
                if (half_over) begin
                    shift_byte_next = shift_in;
                    if (bit_index_reg == 3'd7) begin
                        bit_index_next = 3'd0;
                        phase_next     = i2c_mra_pkg::PH_MACK_LOW;
                    end else begin
                        bit_index_next = bit_index_reg + 3'd1;
                        phase_next     = i2c_mra_pkg::PH_RD_LOW;
                    end
                end
            end
            i2c_mra_pkg::PH_MACK_LOW: begin
                if (half_over) phase_next = i2c_mra_pkg::PH_MACK_HIGH;
            end
            i2c_mra_pkg::PH_MACK_HIGH: begin
                if (half_over) begin
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == 8'd0) begin
                        phase_next = i2c_mra_pkg::PH_STOP_A;
                    end else begin
                        shift_byte_next = 8'd0;
                        phase_next      = i2c_mra_pkg::PH_RD_LOW;
                    end
                end
            end
            i2c_mra_pkg::PH_STOP_A: begin
                if (half_over) phase_next = i2c_mra_pkg::PH_STOP_B;
            end
            i2c_mra_pkg::PH_STOP_B: begin
                if (half_over) phase_next = i2c_mra_pkg::PH_STOP_C;
            end
            i2c_mra_pkg::PH_STOP_C: begin
                if (half_over) begin
                    failed_next = 1'b0;
                    phase_next  = i2c_mra_pkg::PH_IDLE;
                end
            end
            default: begin
                phase_next      = i2c_mra_pkg::PH_IDLE;
                tick_count_next = 16'd0;
            end
        endcase
    end

    // outputs of the word being taken
    always_comb begin
        scl_next    = 1'b1;
        sda_next    = 1'b1;
        drive_next  = 1'b1;
        busy_next   = (phase_eff != i2c_mra_pkg::PH_IDLE);
        bvalid_next = 1'b0;
        rbyte_next  = 8'd0;
        last_next   = 1'b0;
        done_next   = 1'b0;
        stat_next   = 1'b0;

        case (phase_eff)
            i2c_mra_pkg::PH_START_B: sda_next = 1'b0;
            i2c_mra_pkg::PH_BIT_LOW: begin
                scl_next = 1'b0;
                sda_next = shift_byte_reg[7];
            end
            i2c_mra_pkg::PH_BIT_HIGH: sda_next = shift_byte_reg[7];
            i2c_mra_pkg::PH_ACK_LOW: begin
                scl_next   = 1'b0;
                drive_next = 1'b0;
            end
            i2c_mra_pkg::PH_ACK_WAIT: drive_next = 1'b0;
            i2c_mra_pkg::PH_RSTART: scl_next = 1'b0;
            i2c_mra_pkg::PH_RD_LOW: begin
                scl_next   = 1'b0;
                drive_next = 1'b0;
            end
            i2c_mra_pkg::PH_RD_HIGH: begin
                drive_next = 1'b0;
                if (half_over && bit_index_reg == 3'd7) begin
                    bvalid_next = 1'b1;
                    rbyte_next  = shift_in;
                    last_next   = (bytes_left_reg == 8'd1);
                end
            end
            i2c_mra_pkg::PH_MACK_LOW: begin
                scl_next = 1'b0;
                sda_next = (bytes_left_reg == 8'd1);
            end
            i2c_mra_pkg::PH_MACK_HIGH: sda_next = (bytes_left_reg == 8'd1);
            i2c_mra_pkg::PH_STOP_A: begin
                scl_next = 1'b0;
                sda_next = 1'b0;
            end
            i2c_mra_pkg::PH_STOP_B: sda_next = 1'b0;
            i2c_mra_pkg::PH_STOP_C: begin
                if (half_over) begin
                    done_next = 1'b1;
                    stat_next = failed_reg;
                end
            end
            default: begin
                scl_next = 1'b1;
                sda_next = 1'b1;
            end
        endcase
    end

    assign m_valid_next = s_accept || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= i2c_mra_pkg::HALF_PERIOD_RESET;
            ack_timeout_reg <= i2c_mra_pkg::ACK_TIMEOUT_RESET;
        end else if (cfg_we) begin
            if (cfg_addr == i2c_mra_pkg::REG_HALF_PERIOD) begin
                half_period_reg <= cfg_wdata;
            end else if (cfg_addr == i2c_mra_pkg::REG_ACK_TIMEOUT) begin
                ack_timeout_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= i2c_mra_pkg::PH_IDLE;
            byte_no_reg    <= i2c_mra_pkg::BYTE_DEV;
            bit_index_reg  <= 3'd0;
            shift_byte_reg <= 8'd0;
            bytes_left_reg <= 8'd0;
            tick_count_reg <= 16'd0;
            wait_count_reg <= 16'd0;
            saved_dev_reg  <= 8'd0;
            saved_reg_reg  <= 8'd0;
            saved_data_reg <= 8'd0;
            is_read_reg    <= 1'b0;
            failed_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_accept) begin
                phase_reg      <= phase_next;
                byte_no_reg    <= byte_no_next;
                bit_index_reg  <= bit_index_next;
                shift_byte_reg <= shift_byte_next;
                bytes_left_reg <= bytes_left_next;
                tick_count_reg <= tick_count_next;
                wait_count_reg <= wait_count_next;
                saved_dev_reg  <= saved_dev_next;
                saved_reg_reg  <= saved_reg_next;
                saved_data_reg <= saved_data_next;
                is_read_reg    <= is_read_next;
                failed_reg     <= failed_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
            drive_reg  <= drive_next;
            busy_reg   <= busy_next;
            bvalid_reg <= bvalid_next;
            rbyte_reg  <= rbyte_next;
            last_reg   <= last_next;
            done_reg   <= done_next;
            stat_reg   <= stat_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_scl           = scl_reg;
    assign m_sda_out       = sda_reg;
    assign m_sda_is_output = drive_reg;
    assign m_busy_res      = busy_reg;
    assign m_byte_valid    = bvalid_reg;
    assign m_read_byte     = rbyte_reg;
    assign m_last_byte     = last_reg;
    assign m_done_res      = done_reg;
    assign m_status        = stat_reg;

endmodule

`default_nettype wire
